[hdl/lsh_pkg.sv]
// shared constants, types and tables for the lane steering block
`default_nettype none
package lsh_pkg;
  localparam int AngleFracBitsDef = 12;
  localparam logic [14:0] ThRightLo = 15'd13271;
  localparam logic [14:0] ThRightHi = 15'd24986;
  localparam logic [14:0] ThLeftLo  = 15'd655;
  localparam logic [14:0] ThLeftHi  = 15'd12042;
  localparam logic [14:0] ThHorLo   = 15'd11469;
  localparam logic [14:0] ThHorHi   = 15'd14254;
  localparam logic signed [18:0] PiQ16 = 19'sd205887;
  localparam logic signed [18:0] HalfPiQ16 = 19'sd102944;
  localparam logic signed [17:0] CordicKQ14 = 18'sd9949;
  localparam int CordicSteps = 16;

  localparam logic [2:0] REG_MID  = 3'd0;
  localparam logic [2:0] REG_ROI  = 3'd1;
  localparam logic [2:0] REG_KP   = 3'd2;
  localparam logic [2:0] REG_KI   = 3'd3;
  localparam logic [2:0] REG_KD   = 3'd4;

  typedef struct packed {
    logic line_go;
    logic frame_go;
    logic sc_start;
    logic sc_step;
    logic sc_sel_right;
    logic geo_go;
    logic [2:0] geo_phase;
    logic at_start;
    logic at_norm;
    logic at_step;
    logic pid_go;
    logic [1:0] pid_phase;
    logic clear_frame;
  } lsh_cmd_t;

  typedef struct packed {
    logic at_norm_done;
    logic special;
  } lsh_sts_t;

  function automatic logic signed [18:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: return 19'sd51472;
      4'd1: return 19'sd30386;
      4'd2: return 19'sd16055;
      4'd3: return 19'sd8150;
      4'd4: return 19'sd4091;
      4'd5: return 19'sd2047;
      4'd6: return 19'sd1024;
      4'd7: return 19'sd512;
      4'd8: return 19'sd256;
      4'd9: return 19'sd128;
      4'd10: return 19'sd64;
      4'd11: return 19'sd32;
      4'd12: return 19'sd16;
      4'd13: return 19'sd8;
      4'd14: return 19'sd4;
      default: return 19'sd2;
    endcase
  endfunction
endpackage
`default_nettype wire

[hdl/lsh_if.sv]
// valid/ready channel interfaces
`default_nettype none
interface lsh_in_if;
  logic valid;
  logic ready;
  logic op;
  logic signed [14:0] rho;
  logic [14:0] theta;
  modport source (output valid, op, rho, theta, input ready);
  modport sink (input valid, op, rho, theta, output ready);
endinterface

interface lsh_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] steering_angle;
  logic left_found;
  logic right_found;
  logic [15:0] horizontal_run;
  logic [15:0] max_horizontal_run;
  modport source (output valid, steering_angle, left_found, right_found,
                  horizontal_run, max_horizontal_run, input ready);
  modport sink (input valid, steering_angle, left_found, right_found,
                horizontal_run, max_horizontal_run, output ready);
endinterface

interface lsh_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/lsh_datapath.sv]
// datapath: line selection, cordic sin/cos, geometry, atan vectoring, pid
`default_nettype none
module lsh_datapath #(
  parameter int AngleFracBits = lsh_pkg::AngleFracBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire lsh_pkg::lsh_cmd_t cmd_i,
  output lsh_pkg::lsh_sts_t sts_o,
  input  wire logic [3:0] step_i,
  input  wire logic in_op_i,
  input  wire logic signed [14:0] in_rho_i,
  input  wire logic [14:0] in_theta_i,
  input  wire logic [9:0] mid_i,
  input  wire logic [9:0] roi_i,
  input  wire logic [15:0] kp_i,
  input  wire logic [15:0] ki_i,
  input  wire logic [15:0] kd_i,
  output logic signed [31:0] steer_o,
  output logic left_o,
  output logic right_o,
  output logic [15:0] run_o,
  output logic [15:0] max_o
);
  import lsh_pkg::*;
  localparam int Sh = 16 - AngleFracBits;

  logic signed [14:0] lrho_q, rrho_q;
  logic [14:0] lth_q, rth_q;
  logic hor_q;
  logic [15:0] run_q, rmax_q;
  logic lfo_q, rfo_q;
  logic signed [31:0] e0_q, e1_q, e2_q, acc_q;

  // frame tracking
  logic [15:0] run_n;
  always_comb begin
    run_n = run_q;
    if (hor_q) begin
      if (run_q != 16'hFFFF) run_n = run_q + 16'd1;
    end else begin
      run_n = '0;
    end
  end

  wire lf = lrho_q != 0;
  wire rf = rrho_q != 0;
  assign sts_o.special = !(lf && rf);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lrho_q <= '0; rrho_q <= '0; lth_q <= '0; rth_q <= '0; hor_q <= 1'b0;
      run_q <= '0; rmax_q <= '0; lfo_q <= 1'b0; rfo_q <= 1'b0;
    end else if (cmd_i.line_go) begin
      if (in_rho_i < 0 && in_theta_i > ThRightLo && in_theta_i < ThRightHi &&
          in_rho_i < rrho_q) begin
        rrho_q <= in_rho_i; rth_q <= in_theta_i;
      end
      if (in_rho_i > 0 && in_theta_i > ThLeftLo && in_theta_i < ThLeftHi &&
          in_rho_i > lrho_q) begin
        lrho_q <= in_rho_i; lth_q <= in_theta_i;
      end
      if (in_theta_i >= ThHorLo && in_theta_i <= ThHorHi) hor_q <= 1'b1;
    end else if (cmd_i.frame_go) begin
      run_q <= run_n;
      if (run_n > rmax_q) rmax_q <= run_n;
    end else if (cmd_i.clear_frame) begin
      // keep the found flags for the result while the frame state clears
      lfo_q <= lf; rfo_q <= rf;
      lrho_q <= '0; rrho_q <= '0; lth_q <= '0; rth_q <= '0; hor_q <= 1'b0;
    end
  end

  // shared cordic rotation unit for sin/cos
  logic signed [18:0] sz_q;
  logic signed [17:0] sx_q, sy_q;
  logic smir_q;
  logic signed [17:0] s1_q, c1_q, s2_q, c2_q;
  logic signed [18:0] z0;
  always_comb z0 = $signed({1'b0, cmd_i.sc_sel_right ? rth_q : lth_q, 3'b000});
  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_start) begin
      sx_q <= CordicKQ14; sy_q <= '0;
      if (z0 > HalfPiQ16) begin sz_q <= PiQ16 - z0; smir_q <= 1'b1; end
      else begin sz_q <= z0; smir_q <= 1'b0; end
    end else if (cmd_i.sc_step) begin
      if (sz_q >= 0) begin
        sx_q <= sx_q - (sy_q >>> step_i); sy_q <= sy_q + (sx_q >>> step_i);
        sz_q <= sz_q - atan_q16(step_i);
      end else begin
        sx_q <= sx_q + (sy_q >>> step_i); sy_q <= sy_q - (sx_q >>> step_i);
        sz_q <= sz_q + atan_q16(step_i);
      end
    end
  end
  // latch results in the cycle after the last step, via geo phase 0
  logic signed [35:0] s28_q;
  logic signed [35:0] xnum_q;
  logic signed [47:0] x28_q, a_q;
  logic signed [63:0] num_q, den_q, t_q;
  logic signed [59:0] p_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.geo_go) begin
      case (cmd_i.geo_phase)
        3'd0: begin
          // the left capture shares its cycle with the start of the right pass
          if (cmd_i.sc_sel_right && !cmd_i.sc_start) begin
            s2_q <= sy_q; c2_q <= smir_q ? -sx_q : sx_q;
          end else begin
            s1_q <= sy_q; c1_q <= smir_q ? -sx_q : sx_q;
          end
        end
        3'd1: begin
          s28_q <= 36'(s1_q * c2_q) + 36'(c1_q * s2_q);
          xnum_q <= 36'(lrho_q * s2_q) - 36'(rrho_q * s1_q);
        end
        3'd2: begin
          x28_q <= 48'(xnum_q) <<< 10;
          a_q <= (48'(xnum_q) <<< 10) - 48'($signed({1'b0, mid_i}) * s28_q);
          t_q <= 64'($signed({1'b0, roi_i}) * s28_q);
        end
        3'd3: begin
          num_q <= 64'(a_q * s2_q);
          p_q <= 60'(t_q * s2_q);
        end
        3'd4: begin
          den_q <= 64'(p_q) - 64'(x28_q * c2_q);
          t_q <= 64'(rrho_q * s28_q) <<< 10;
        end
        default: begin
          den_q <= den_q - t_q;
        end
      endcase
    end
  end

  // atan vectoring unit
  logic signed [63:0] an_q, ad_q;
  logic signed [19:0] az_q;
  logic azero_q;
  wire [63:0] an_abs = an_q[63] ? -an_q : an_q;
  wire big = (an_abs >= 64'd1 << 40) || (ad_q >= 64'sd1 <<< 40);
  wire low_mag = (an_abs < 64'd1 << 30) && (ad_q < 64'sd1 <<< 30);
  assign sts_o.at_norm_done = azero_q || (!big && !low_mag);
  always_ff @(posedge clk_i) begin
    if (cmd_i.at_start) begin
      azero_q <= den_q == 0;
      if (den_q == 0) begin
        az_q <= num_q > 0 ? 20'(HalfPiQ16) : (num_q < 0 ? -20'(HalfPiQ16) : '0);
      end else begin
        az_q <= '0;
      end
      if (den_q < 0) begin an_q <= -num_q; ad_q <= -den_q; end
      else begin an_q <= num_q; ad_q <= den_q; end
    end else if (cmd_i.at_norm && !azero_q) begin
      if (big) begin an_q <= an_q >>> 1; ad_q <= ad_q >>> 1; end
      else if (low_mag) begin an_q <= an_q <<< 1; ad_q <= ad_q <<< 1; end
    end else if (cmd_i.at_step && !azero_q) begin
      if (an_q >= 0) begin
        ad_q <= ad_q + (an_q >>> step_i); an_q <= an_q - (ad_q >>> step_i);
        az_q <= az_q + 20'(atan_q16(step_i));
      end else begin
        ad_q <= ad_q - (an_q >>> step_i); an_q <= an_q + (ad_q >>> step_i);
        az_q <= az_q - 20'(atan_q16(step_i));
      end
    end
  end

  logic signed [31:0] err;
  always_comb begin
    if (lf && !rf) err = 32'sd14 <<< AngleFracBits;
    else if (rf && !lf) err = -(32'sd12 <<< AngleFracBits);
    else if (!lf) err = '0;
    else if (Sh == 0) err = 32'(az_q);
    else err = 32'((32'(az_q) + (32'sd1 <<< (Sh > 0 ? Sh - 1 : 0))) >>> Sh);
  end

  // pid
  logic signed [50:0] pa_q, pb_q, pc_q;
  logic signed [52:0] ch;
  logic signed [40:0] chr;
  logic signed [41:0] sum;
  always_comb begin
    ch = 53'(pa_q) + 53'(pb_q) + 53'(pc_q) + 53'sd2048;
    chr = 41'(ch >>> 12);
    sum = 42'(acc_q) + 42'(chr);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_q <= '0; e1_q <= '0; e2_q <= '0; acc_q <= '0;
      pa_q <= '0; pb_q <= '0; pc_q <= '0;
    end else if (cmd_i.pid_go) begin
      case (cmd_i.pid_phase)
        2'd0: begin e2_q <= e1_q; e1_q <= e0_q; e0_q <= err; end
        2'd1: begin
          pa_q <= 51'($signed({1'b0, kp_i}) * (34'(e0_q) - 34'(e1_q)));
          pb_q <= 51'($signed({1'b0, ki_i}) * 34'(e0_q));
          pc_q <= 51'($signed({1'b0, kd_i}) *
                  (35'(e0_q) - (35'(e1_q) <<< 1) + 35'(e2_q)));
        end
        default: begin
          if (sum > 42'sd2147483647) acc_q <= 32'sh7FFFFFFF;
          else if (sum < -42'sd2147483648) acc_q <= 32'sh80000000;
          else acc_q <= 32'(sum);
        end
      endcase
    end
  end

  assign steer_o = acc_q;
  assign left_o = lfo_q;
  assign right_o = rfo_q;
  assign run_o = run_q;
  assign max_o = rmax_q;
  wire unused = in_op_i;
endmodule
`default_nettype wire

[hdl/lsh_ctrl.sv]
// controller sequencing frame-end computation
`default_nettype none
module lsh_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_op_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  input  wire lsh_pkg::lsh_sts_t sts_i,
  output lsh_pkg::lsh_cmd_t cmd_o,
  output logic [3:0] step_o
);
  import lsh_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_RUN = 4'd1, S_SC1 = 4'd2, S_G0A = 4'd3,
    S_SC2 = 4'd4, S_G0B = 4'd5, S_GEO = 4'd6, S_ATS = 4'd7, S_ATN = 4'd8,
    S_ATI = 4'd9, S_PID = 4'd10, S_OUT = 4'd11;
  logic [3:0] st_q, st_d;
  logic [3:0] cnt_q, cnt_d;
  logic ov_q, ov_d;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; ov_d = ov_q;
    cmd_o = '0;
    step_o = cnt_q;
    in_ready_o = (st_q == S_IDLE) && !ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: if (in_valid_i && in_ready_o) begin
        if (!in_op_i) cmd_o.line_go = 1'b1;
        else begin cmd_o.frame_go = 1'b1; st_d = S_RUN; end
      end
      S_RUN: begin
        if (sts_i.special) begin st_d = S_PID; cnt_d = '0; end
        else begin cmd_o.sc_start = 1'b1; st_d = S_SC1; cnt_d = '0; end
      end
      S_SC1: begin
        cmd_o.sc_step = 1'b1; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) st_d = S_G0A;
      end
      S_G0A: begin
        cmd_o.geo_go = 1'b1; cmd_o.geo_phase = 3'd0;
        cmd_o.sc_sel_right = 1'b1; cmd_o.sc_start = 1'b1; st_d = S_SC2;
      end
      S_SC2: begin
        cmd_o.sc_sel_right = 1'b1; cmd_o.sc_step = 1'b1; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) st_d = S_G0B;
      end
      S_G0B: begin
        cmd_o.geo_go = 1'b1; cmd_o.geo_phase = 3'd0; cmd_o.sc_sel_right = 1'b1;
        st_d = S_GEO; cnt_d = 4'd1;
      end
      S_GEO: begin
        cmd_o.geo_go = 1'b1; cmd_o.geo_phase = cnt_q[2:0]; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd5) st_d = S_ATS;
      end
      S_ATS: begin cmd_o.at_start = 1'b1; st_d = S_ATN; end
      S_ATN: begin
        cmd_o.at_norm = 1'b1;
        if (sts_i.at_norm_done) begin st_d = S_ATI; cnt_d = '0; end
      end
      S_ATI: begin
        cmd_o.at_step = 1'b1; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin st_d = S_PID; cnt_d = '0; end
      end
      S_PID: begin
        cmd_o.pid_go = 1'b1; cmd_o.pid_phase = cnt_q[1:0]; cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q) begin ov_d = 1'b1; st_d = S_IDLE; cmd_o.clear_frame = 1'b1; end
      end
      default: st_d = S_IDLE;
    endcase
  end
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin st_q <= S_IDLE; cnt_q <= '0; ov_q <= 1'b0; end
    else begin st_q <= st_d; cnt_q <= cnt_d; ov_q <= ov_d; end
  end
endmodule
`default_nettype wire

[hdl/lane_steering_from_hough_lines.sv]
// top level of the lane steering block
// in: one transfer per hough line (op=0) or end of frame (op=1).
// a line transfer gives no result.
// a frame end gives one result on the out channel. with only one or no
// lane line the controller goes straight to the pid; with both lines the
// shared cordic unit runs 16 steps for each line, then come the geometry
// phases, a normalize loop and 16 atan steps before the pid.
// the result waits in an output register; the next frame's lines are
// taken once that register is free, so a stalled receiver holds input.
// cfg: register index and data; user writes only when idle, not enforced.
// reset clears all frame state, run counters, pid history and accumulator
// and loads the register defaults.
`default_nettype none
module lane_steering_from_hough_lines #(
  parameter int AngleFracBits = lsh_pkg::AngleFracBitsDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lsh_in_if.sink in_ch,
  lsh_out_if.source out_ch,
  lsh_cfg_if.sink cfg_ch
);
  import lsh_pkg::*;
  lsh_cmd_t cmd;
  lsh_sts_t sts;
  logic [3:0] step;
  logic [9:0] mid_q, roi_q;
  logic [15:0] kp_q, ki_q, kd_q;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 10'd320; roi_q <= 10'd160;
      kp_q <= 16'd4096; ki_q <= 16'd102; kd_q <= 16'd819;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MID: mid_q <= cfg_ch.data[9:0];
        REG_ROI: roi_q <= cfg_ch.data[9:0];
        REG_KP: kp_q <= cfg_ch.data;
        REG_KI: ki_q <= cfg_ch.data;
        REG_KD: kd_q <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  lsh_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_op_i(in_ch.op), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .sts_i(sts), .cmd_o(cmd), .step_o(step)
  );

  lsh_datapath #(.AngleFracBits(AngleFracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .step_i(step),
    .in_op_i(in_ch.op), .in_rho_i(in_ch.rho), .in_theta_i(in_ch.theta),
    .mid_i(mid_q), .roi_i(roi_q), .kp_i(kp_q), .ki_i(ki_q), .kd_i(kd_q),
    .steer_o(out_ch.steering_angle), .left_o(out_ch.left_found),
    .right_o(out_ch.right_found), .run_o(out_ch.horizontal_run),
    .max_o(out_ch.max_horizontal_run)
  );
endmodule
`default_nettype wire

[hdl/lsh_checker.sv]
// port-level checker bound to the top level
`default_nettype none
module lsh_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] run,
  input wire logic [15:0] maxrun
);
  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> maxrun >= run) else $error("max run below run");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_noin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !out_valid) else $error("result right after input transfer");
endmodule

bind lane_steering_from_hough_lines lsh_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .run(out_ch.horizontal_run), .maxrun(out_ch.max_horizontal_run)
);
`default_nettype wire
